@@ rtl/ccwc_pkg.sv @@
package ccwc_pkg;

  localparam int AMOUNT_DEPTH = 65536;
  localparam int AMOUNT_W     = $clog2(AMOUNT_DEPTH);
  localparam int COIN_SLOTS   = 8;
  localparam int SLOT_W       = $clog2(COIN_SLOTS);
  localparam int COIN_W       = 16;
  localparam int QUERY_W      = 16;
  localparam int WAY_W        = 30;
  localparam int REG_COUNT    = 8;
  localparam int CFG_IDX_W    = 8;

  localparam logic [WAY_W-1:0] WAY_MOD = WAY_W'(1000000007);

  typedef logic [COIN_W-1:0] coin_t;

  localparam coin_t COIN_RESET [REG_COUNT] = '{
    16'd1, 16'd2, 16'd5, 16'd10, 16'd20, 16'd50, 16'd100, 16'd200
  };

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_SEL,
    ST_RD,
    ST_UPD,
    ST_FETCH,
    ST_LOAD
  } state_t;

endpackage

@@ rtl/ccwc_ram.sv @@
module ccwc_ram #(
  parameter int WIDTH = 30,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

@@ rtl/coin_change_way_counter.sv @@
// Counts the unordered ways to reach a query amount q from the eight
// configured coin values, modulo 1000000007; a coin value of zero leaves its
// slot unused and two slots of equal value count as distinct coins. Each
// query runs the unbounded coin-change recurrence in one tally RAM through a
// single modular adder: it initializes the tally for amounts 0 to q, selects
// each coin slot in turn, and for each used coin c not above q does a read
// and an add-and-write per amount from c to q; it then reads out the answer
// and returns to idle to take the next query. The input is ready only between
// queries; the result waits in an output register, and the next query may
// start while it is still waiting. Coin values are written through the cfg
// port; the user must write them only while no query is in flight, as the
// block itself does not enforce it.
module coin_change_way_counter (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [15:0]                       in_tdata,   // [15:0] query_amount
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [31:0]                       out_tdata,  // [29:0] way_count
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [ccwc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ccwc_pkg::COIN_W-1:0]       cfg_data
);

  import ccwc_pkg::*;

  state_t              state_r, state_nxt;
  logic [AMOUNT_W-1:0] q_r, q_nxt;
  logic [AMOUNT_W-1:0] a_r, a_nxt;
  logic [SLOT_W-1:0]   k_r, k_nxt;
  coin_t               coin_r [REG_COUNT];
  logic [WAY_W-1:0]    out_data_r;
  logic                out_valid_r;

  logic                ram_we;
  logic [AMOUNT_W-1:0] ram_waddr;
  logic [WAY_W-1:0]    ram_wdata;
  logic [AMOUNT_W-1:0] ram_raddr_a;
  logic [AMOUNT_W-1:0] ram_raddr_b;
  logic [WAY_W-1:0]    ram_rdata_a;
  logic [WAY_W-1:0]    ram_rdata_b;

  logic [AMOUNT_W-1:0] cval;
  logic                coin_skip;
  logic                last_slot;
  logic [WAY_W:0]      sum;
  logic [WAY_W-1:0]    sum_mod;
  logic                out_free;
  logic                q_range_ok;

  ccwc_ram #(
    .WIDTH(WAY_W),
    .DEPTH(AMOUNT_DEPTH)
  ) u_tally (
    .clk    (clk),
    .we     (ram_we),
    .waddr  (ram_waddr),
    .wdata  (ram_wdata),
    .raddr_a(ram_raddr_a),
    .raddr_b(ram_raddr_b),
    .rdata_a(ram_rdata_a),
    .rdata_b(ram_rdata_b)
  );

  assign cval       = AMOUNT_W'(coin_r[k_r]);
  assign coin_skip  = (coin_r[k_r] == '0) || (cval > q_r);
  assign last_slot  = (k_r == SLOT_W'(COIN_SLOTS - 1));
  assign sum        = {1'b0, ram_rdata_a} + {1'b0, ram_rdata_b};
  assign sum_mod    = (sum >= {1'b0, WAY_MOD}) ? WAY_W'(sum - {1'b0, WAY_MOD})
                                                : WAY_W'(sum);
  assign out_free   = !out_valid_r || out_tready;
  assign q_range_ok = ({1'b0, in_tdata[QUERY_W-1:0]} < (QUERY_W+1)'(AMOUNT_DEPTH));

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(32-WAY_W){1'b0}}, out_data_r};
  assign cfg_ready  = 1'b1;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          state_nxt = q_range_ok ? ST_CLEAR : ST_LOAD;
        end
      end
      ST_CLEAR: begin
        if (a_r == q_r) begin
          state_nxt = ST_SEL;
        end
      end
      ST_SEL: begin
        if (!coin_skip) begin
          state_nxt = ST_RD;
        end else if (last_slot) begin
          state_nxt = ST_FETCH;
        end
      end
      ST_RD: begin
        state_nxt = ST_UPD;
      end
      ST_UPD: begin
        if (a_r != q_r) begin
          state_nxt = ST_RD;
        end else if (last_slot) begin
          state_nxt = ST_FETCH;
        end else begin
          state_nxt = ST_SEL;
        end
      end
      ST_FETCH: begin
        state_nxt = ST_LOAD;
      end
      ST_LOAD: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs and counters
  always_comb begin
    q_nxt       = q_r;
    a_nxt       = a_r;
    k_nxt       = k_r;
    ram_we      = 1'b0;
    ram_waddr   = a_r;
    ram_wdata   = '0;
    ram_raddr_a = a_r;
    ram_raddr_b = a_r - cval;
    unique case (state_r)
      ST_IDLE: begin
        q_nxt = AMOUNT_W'(in_tdata[QUERY_W-1:0]);
        a_nxt = '0;
        k_nxt = '0;
      end
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_wdata = (a_r == '0) ? WAY_W'(1) : '0;
        a_nxt     = a_r + 1'b1;
      end
      ST_SEL: begin
        a_nxt = cval;
        if (coin_skip && !last_slot) begin
          k_nxt = k_r + 1'b1;
        end
      end
      ST_RD: begin
      end
      ST_UPD: begin
        ram_we    = 1'b1;
        ram_wdata = sum_mod;
        if (a_r != q_r) begin
          a_nxt = a_r + 1'b1;
        end else if (!last_slot) begin
          k_nxt = k_r + 1'b1;
        end
      end
      ST_FETCH: begin
        ram_raddr_a = q_r;
      end
      ST_LOAD: begin
        ram_raddr_a = q_r;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      q_r         <= '0;
      a_r         <= '0;
      k_r         <= '0;
      for (int i = 0; i < REG_COUNT; i++) begin
        coin_r[i] <= COIN_RESET[i];
      end
    end else begin
      state_r <= state_nxt;
      q_r     <= q_nxt;
      a_r     <= a_nxt;
      k_r     <= k_nxt;
      if (cfg_valid && (cfg_index < CFG_IDX_W'(REG_COUNT))) begin
        coin_r[cfg_index[SLOT_W-1:0]] <= cfg_data;
      end
      if (state_r == ST_LOAD && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // out-of-range queries skip the walk and answer zero; otherwise the answer is the tally read at q
  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && in_tvalid && !q_range_ok && out_free) begin
      out_data_r <= '0;
    end else if (state_r == ST_LOAD && out_free) begin
      out_data_r <= ram_rdata_a;
    end
  end

endmodule

@@ test/coin_change_way_counter_test.sv @@
module coin_change_way_counter_test;
  import ccwc_pkg::*;

  localparam int LONG_HOLD = 20000;

  // expected way counts, predicted from the coin registers at query time
  class way_ledger;
    coin_t coins [REG_COUNT];
    logic [WAY_W-1:0] owed_counts [$];
    int errors;

    function new();
      foreach (coins[i]) coins[i] = COIN_RESET[i];
      errors = 0;
    endfunction

    function void set_coin(int idx, coin_t value);
      if (idx >= 0 && idx < REG_COUNT) coins[idx] = value;
    endfunction

    function logic [WAY_W-1:0] count_ways(int unsigned amount);
      int unsigned tally [];
      int unsigned c;
      tally = new[amount + 1];
      foreach (tally[i]) tally[i] = 0;
      tally[0] = 1;
      for (int s = 0; s < COIN_SLOTS && s < REG_COUNT; s++) begin
        c = coins[s];
        if (c == 0 || c > amount) continue;
        for (int unsigned a = c; a <= amount; a++) begin
          tally[a] = tally[a] + tally[a - c];
          if (tally[a] >= int'(WAY_MOD)) tally[a] = tally[a] - int'(WAY_MOD);
        end
      end
      return tally[amount][WAY_W-1:0];
    endfunction

    function void note_query(logic [QUERY_W-1:0] amount);
      owed_counts.push_back(count_ways(amount));
    endfunction

    function void flag(string msg);
      errors++;
      if (errors <= 10) $display("mismatch: %s", msg);
    endfunction

    function void check_count(logic [WAY_W-1:0] got);
      logic [WAY_W-1:0] want;
      if (owed_counts.size() == 0) begin
        flag($sformatf("way_count %0d with no query outstanding", got));
        return;
      end
      want = owed_counts.pop_front();
      if (got !== want) flag($sformatf("way_count expected %0d actual %0d", want, got));
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_tvalid = 1'b0;
  logic                 in_tready;
  logic [15:0]          in_tdata = '0;
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [31:0]          out_tdata;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [COIN_W-1:0]    cfg_data = '0;

  way_ledger ledger = new();
  int        idle_pct = 0;
  int        hold_cycles = 0;
  coin_t     next_coins [REG_COUNT];

  always #1 clk = ~clk;

  coin_change_way_counter u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  function automatic int gap_cycles();
    if ($urandom_range(0, 9) == 0) return $urandom_range(20, 200);
    return $urandom_range(1, 3);
  endfunction

  function automatic coin_t random_coin();
    case ($urandom_range(0, 9))
      0, 1: return '0;
      8: return coin_t'($urandom_range(13, 300));
      9: return coin_t'($urandom_range(1, 4));
      default: return coin_t'($urandom_range(1, 12));
    endcase
  endfunction

  function automatic logic [QUERY_W-1:0] modest_amount();
    if ($urandom_range(0, 15) == 0) return QUERY_W'($urandom_range(256, 1023));
    return QUERY_W'($urandom_range(0, 255));
  endfunction

  // valid stays high after a transfer; the caller drops it
  task automatic write_reg(input int idx, input coin_t value);
    cfg_index <= idx[CFG_IDX_W-1:0];
    cfg_data  <= value;
    cfg_valid <= 1'b1;
    @(negedge clk);
    while (!cfg_ready) @(negedge clk);
    @(posedge clk);
    ledger.set_coin(idx, value);
  endtask

  task automatic load_coins();
    for (int i = 0; i < REG_COUNT; i++) write_reg(i, next_coins[i]);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_query(input logic [QUERY_W-1:0] amount);
    in_tdata  <= amount;
    in_tvalid <= 1'b1;
    @(negedge clk);
    while (!in_tready) @(negedge clk);
    @(posedge clk);
    ledger.note_query(amount);
  endtask

  task automatic sender_idle(input int cycles);
    in_tvalid <= 1'b0;
    in_tdata  <= 16'($urandom);
    repeat (cycles) @(posedge clk);
  endtask

  task automatic maybe_idle();
    if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) sender_idle(gap_cycles());
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (ledger.owed_counts.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // result side: random stalls plus one long hold requested by the stimulus
  initial begin : result_sink
    wait (rst_n);
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        out_tready <= 1'b0;
        repeat (hold_cycles) @(posedge clk);
        hold_cycles = 0;
      end else if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
        out_tready <= 1'b0;
        repeat (gap_cycles()) @(posedge clk);
      end
      out_tready <= 1'b1;
    end
  end

  always @(negedge clk) begin
    if (rst_n && out_tvalid && out_tready) ledger.check_count(out_tdata[WAY_W-1:0]);
  end

  initial begin : stimulus
    logic [QUERY_W-1:0] directed [$];
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // out of range register indexes must leave the coins alone
    write_reg(REG_COUNT, 16'd3);
    write_reg(255, 16'hFFFF);
    cfg_valid <= 1'b0;

    idle_pct = 20;
    directed = '{16'd0, 16'd1, 16'd2, 16'd5, 16'd7, 16'd100, 16'd199, 16'd200, 16'd300};
    foreach (directed[i]) begin
      send_query(directed[i]);
      maybe_idle();
    end
    drain();

    // eight equal coins: counts wrap the modulus
    foreach (next_coins[i]) next_coins[i] = 16'd1;
    load_coins();
    directed = '{16'd0, 16'd150, 16'd255};
    foreach (directed[i]) begin
      send_query(directed[i]);
      maybe_idle();
    end
    drain();

    // huge coins and unused slots keep full range amounts cheap
    next_coins = '{16'd0, 16'hFFFF, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd60000};
    load_coins();
    directed = '{16'd0, 16'd1, 16'd59999, 16'd60000, 16'hFFFF, 16'h8000};
    foreach (directed[i]) begin
      send_query(directed[i]);
      maybe_idle();
    end
    repeat (3) begin
      send_query(QUERY_W'($urandom_range(0, 65535)));
      maybe_idle();
    end
    drain();

    for (int phase = 0; phase < 4; phase++) begin
      idle_pct = (phase == 1) ? 0 : 10 + 10 * phase;
      foreach (next_coins[i]) next_coins[i] = random_coin();
      load_coins();
      if (phase == 0) hold_cycles = LONG_HOLD;
      repeat (22) begin
        send_query(modest_amount());
        maybe_idle();
      end
      drain();
    end

    repeat (200) @(posedge clk);
    if (ledger.errors == 0 && ledger.owed_counts.size() == 0) begin
      $display("PASS coin_change_way_counter");
    end else begin
      $display("FAIL coin_change_way_counter");
    end
    $finish;
  end

  initial begin : watchdog
    #20_000_000;
    $display("FAIL coin_change_way_counter");
    $finish;
  end

endmodule
